// ===== rtl/mml_pkg.sv =====
`default_nettype none

package mml_pkg;

    // Defaults for the top-level parameters
    localparam int OVERSAMPLE_DEF   = 4;
    localparam int SAMPLE_WIDTH_DEF = 24;

    // Filter mode codes
    localparam logic [1:0] MODE_LPF_2POLE = 2'd0;
    localparam logic [1:0] MODE_LPF_4POLE = 2'd1;
    localparam logic [1:0] MODE_HP6       = 2'd2;
    localparam logic [1:0] MODE_BP        = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_LADDER_G = 3'd1;
    localparam logic [2:0] REG_FEEDBACK = 3'd2;
    localparam logic [2:0] REG_RESO     = 3'd3;
    localparam logic [2:0] REG_HP_COEF  = 3'd4;
    localparam logic [2:0] REG_SVF_FREQ = 3'd5;

    // Coefficient constants, Q.16
    localparam int ZERO_TAP_A = 15124;
    localparam int ZERO_TAP_B = 50412;
    localparam int SIXTH      = 10923;
    localparam int UNITY      = 65536;
    localparam int K_MAX      = 249037;
    localparam int F_MAX      = 131072;
    localparam int Q_TOP      = 131072;
    localparam int Q_MIN      = 3277;
    localparam int Q_DIVISOR  = 20;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_COMP,
        ST_FB,
        ST_TX2,
        ST_TNUM,
        ST_TDIV,
        ST_LZA,
        ST_LZB,
        ST_LG,
        ST_C2,
        ST_C3,
        ST_C6,
        ST_GAIN,
        ST_HP,
        ST_SVQ,
        ST_SQ,
        ST_SF1,
        ST_SF2,
        ST_SOUT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/multimode_ladder_filter.sv =====
// Each multiply runs bit-serially on the single serial multiplier, each divide on the
// restoring divider. Per sample, lowpass modes use up to OVERSAMPLE*(15 multiplies +
// 1 divide) plus 2 (2-pole) or 5 (4-pole) multiplies; highpass uses OVERSAMPLE
// multiplies; bandpass 1 divide + 3*OVERSAMPLE+1 multiplies.
// A new sample is taken only after the previous one has gone to the output register.
// Reset (aresetn low, synchronous) clears config registers to defaults and all filter state to zero.
`default_nettype none

module multimode_ladder_filter
    import mml_pkg::*;
#(
    parameter int OVERSAMPLE   = OVERSAMPLE_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [DW-1:0] s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [DW-1:0]      m_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int F   = W - 5;
    localparam int BW  = W + 4;
    localparam int AW  = 2 * BW;
    localparam int IW  = $clog2(OVERSAMPLE + 1);
    localparam int MCW = $clog2(BW);
    localparam int DCW = $clog2(AW);

    localparam logic signed [AW-1:0] ONE_A  = AW'(64'd1 << F);
    localparam logic signed [AW-1:0] FOUR_A = AW'(64'd4 << F);
    localparam logic signed [AW-1:0] SIX_A  = AW'(64'd6 << F);
    localparam logic signed [AW-1:0] TEN_A  = AW'(64'd10 << F);
    localparam logic signed [AW-1:0] C27_A  = AW'(64'd27 << F);
    localparam logic signed [AW-1:0] SMAX_A = AW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [AW-1:0] SMIN_A = -SMAX_A - AW'(1);
    localparam logic signed [AW-1:0] H16    = AW'(64'd1 << 15);
    localparam logic signed [AW-1:0] H17    = AW'(64'd1 << 16);
    localparam logic signed [AW-1:0] HF     = AW'(64'd1 << (F - 1));

    function automatic logic signed [AW-1:0] sx(input logic signed [W-1:0] v);
        return AW'(v);
    endfunction

    function automatic logic signed [AW-1:0] sat_w(input logic signed [AW-1:0] v);
        if (v > SMAX_A) return SMAX_A;
        if (v < SMIN_A) return SMIN_A;
        return v;
    endfunction

    function automatic logic signed [AW-1:0] clampm(input logic signed [AW-1:0] v,
                                                    input logic signed [AW-1:0] lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Configuration registers
    logic [1:0]  filter_mode_reg;
    logic [16:0] ladder_gain_reg;
    logic [17:0] feedback_amount_reg;
    logic [16:0] resonance_reg;
    logic [16:0] highpass_coef_reg;
    logic [17:0] svf_frequency_reg;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg     <= MODE_LPF_2POLE;
            ladder_gain_reg     <= 17'd2090;
            feedback_amount_reg <= 18'd0;
            resonance_reg       <= 17'd0;
            highpass_coef_reg   <= 17'd1055;
            svf_frequency_reg   <= 18'd2144;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_MODE:     filter_mode_reg     <= pwdata[1:0];
                REG_LADDER_G: ladder_gain_reg     <= pwdata[16:0];
                REG_FEEDBACK: feedback_amount_reg <= pwdata[17:0];
                REG_RESO:     resonance_reg       <= pwdata[16:0];
                REG_HP_COEF:  highpass_coef_reg   <= pwdata[16:0];
                REG_SVF_FREQ: svf_frequency_reg   <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MODE:     prdata = 32'(filter_mode_reg);
            REG_LADDER_G: prdata = 32'(ladder_gain_reg);
            REG_FEEDBACK: prdata = 32'(feedback_amount_reg);
            REG_RESO:     prdata = 32'(resonance_reg);
            REG_HP_COEF:  prdata = 32'(highpass_coef_reg);
            REG_SVF_FREQ: prdata = 32'(svf_frequency_reg);
            default:      prdata = 32'd0;
        endcase
    end

    // Clamped coefficients and values derived from resonance
    logic [16:0] r_c, g_c, a_c;
    logic [17:0] k_c, f_c;
    logic signed [AW-1:0] r_a, g_a, a_a, k_a, f_a, gain24_a, bpgain_a, r39_a;

    assign r_c = (resonance_reg > 17'(UNITY)) ? 17'(UNITY) : resonance_reg;
    assign g_c = (ladder_gain_reg > 17'(UNITY)) ? 17'(UNITY) : ladder_gain_reg;
    assign a_c = (highpass_coef_reg > 17'(UNITY)) ? 17'(UNITY) : highpass_coef_reg;
    assign k_c = (feedback_amount_reg > 18'(K_MAX)) ? 18'(K_MAX) : feedback_amount_reg;
    assign f_c = (svf_frequency_reg > 18'(F_MAX)) ? 18'(F_MAX) : svf_frequency_reg;
    assign r_a = AW'(r_c);
    assign g_a = AW'(g_c);
    assign a_a = AW'(a_c);
    assign k_a = AW'(k_c);
    assign f_a = AW'(f_c);
    assign gain24_a = AW'(UNITY) + ((r_a + (r_a <<< 1)) >>> 1);
    assign bpgain_a = AW'(UNITY) + (r_a >>> 1);
    assign r39_a    = (r_a <<< 5) + (r_a <<< 2) + (r_a <<< 1) + r_a + AW'(10);

    // Bit-serial signed multiplier, one multiplier bit per cycle
    logic                 mul_start;
    logic signed [AW-1:0] mul_a_w, mul_b_w;
    logic signed [BW-1:0] ma_reg;
    logic signed [BW:0]   mhi_reg;
    logic [BW-1:0]        mlo_reg;
    logic [MCW-1:0]       mcnt_reg;
    logic                 mbusy_reg, mdone_reg;
    logic signed [BW:0]   m_ae, m_add, m_sum;
    logic                 m_last;

    assign m_ae   = {ma_reg[BW-1], ma_reg};
    assign m_last = (mcnt_reg == MCW'(BW - 1));
    assign m_add  = mlo_reg[0] ? (m_last ? -m_ae : m_ae) : '0;
    assign m_sum  = mhi_reg + m_add;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mdone_reg <= 1'b0;
            mcnt_reg  <= '0;
        end else begin
            mdone_reg <= 1'b0;
            if (mul_start) begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= '0;
            end else if (mbusy_reg) begin
                mcnt_reg <= mcnt_reg + MCW'(1);
                if (m_last) begin
                    mbusy_reg <= 1'b0;
                    mdone_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_start) begin
            ma_reg  <= mul_a_w[BW-1:0];
            mlo_reg <= mul_b_w[BW-1:0];
            mhi_reg <= '0;
        end else if (mbusy_reg) begin
            mhi_reg <= {m_sum[BW], m_sum[BW:1]};
            mlo_reg <= {m_sum[0], mlo_reg[BW-1:1]};
        end
    end

    logic signed [AW-1:0] prod, pr16, pr17, prf;
    assign prod = {mhi_reg[BW-1:0], mlo_reg};
    assign pr16 = (prod + H16) >>> 16;
    assign pr17 = (prod + H17) >>> 17;
    assign prf  = (prod + HF) >>> F;

    // Restoring divider, one quotient bit per cycle
    logic                 div_start;
    logic [AW-1:0]        div_n;
    logic [BW:0]          div_d;
    logic [AW-1:0]        dq_reg;
    logic [BW:0]          drem_reg, dden_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic                 dbusy_reg, ddone_reg;
    logic [BW+1:0]        d_r2;
    logic [BW+2:0]        d_diff;
    logic                 d_ge, d_last;

    assign d_r2   = {drem_reg, dq_reg[AW-1]};
    assign d_diff = {1'b0, d_r2} - {2'b00, dden_reg};
    assign d_ge   = !d_diff[BW+2];
    assign d_last = (dcnt_reg == DCW'(AW - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else begin
            ddone_reg <= 1'b0;
            if (div_start) begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= '0;
            end else if (dbusy_reg) begin
                dcnt_reg <= dcnt_reg + DCW'(1);
                if (d_last) begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            dq_reg   <= div_n;
            dden_reg <= div_d;
            drem_reg <= '0;
        end else if (dbusy_reg) begin
            dq_reg   <= {dq_reg[AW-2:0], d_ge};
            drem_reg <= d_ge ? d_diff[BW:0] : d_r2[BW:0];
        end
    end

    logic signed [AW-1:0] quo;
    assign quo = dq_reg;

    // Sequencer and filter state
    state_t               state_reg, state_next;
    logic                 wait_reg, wait_next;
    logic [1:0]           stage_reg, stage_next;
    logic [IW-1:0]        iter_reg, iter_next;
    logic                 neg_reg, neg_next;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [AW-1:0] comp_reg, comp_next;
    logic signed [AW-1:0] ta_reg, ta_next;
    logic signed [AW-1:0] tb_reg, tb_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [17:0]          q_reg, q_next;
    logic signed [W-1:0]  so_reg [4];
    logic signed [W-1:0]  so_next [4];
    logic signed [W-1:0]  pv_reg [4];
    logic signed [W-1:0]  pv_next [4];
    logic signed [W-1:0]  hs_reg, hs_next;
    logic signed [W-1:0]  slp_reg, slp_next;
    logic signed [W-1:0]  sbp_reg, sbp_next;
    logic signed [W-1:0]  res_reg, res_next;
    logic signed [W-1:0]  out_reg, out_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic signed [AW-1:0] xe, so0e, so3e, pv0e, hse, slpe, sbpe, xin, c_cl;
    logic signed [AW-1:0] t_arg, den, mag, y_lg, hp_v, hp_lp, lpn, qq;
    logic                 last_iter;

    assign xe    = sx(x_reg);
    assign so0e  = sx(so_reg[0]);
    assign so3e  = sx(so_reg[3]);
    assign pv0e  = sx(pv_reg[0]);
    assign hse   = sx(hs_reg);
    assign slpe  = sx(slp_reg);
    assign sbpe  = sx(sbp_reg);
    assign xin   = (stage_reg == 2'd0) ? ta_reg : so3e;
    assign c_cl  = clampm(so3e, SIX_A);
    assign t_arg = xe - pr16;
    assign den   = C27_A + (tb_reg <<< 3) + tb_reg;
    assign mag   = prod[AW-1] ? -prod : prod;
    assign y_lg  = sat_w(so0e + pr16);
    assign hp_v  = pr16;
    assign hp_lp = hp_v + hse;
    assign lpn   = slpe + pr16;
    assign qq    = AW'(Q_TOP) - quo;
    assign last_iter = (iter_reg == IW'(OVERSAMPLE - 1));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DW'($unsigned(out_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wait_reg     <= 1'b0;
            stage_reg    <= 2'd0;
            iter_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            hs_reg       <= '0;
            slp_reg      <= '0;
            sbp_reg      <= '0;
            for (int i = 0; i < 4; i++) begin
                so_reg[i] <= '0;
                pv_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            wait_reg     <= wait_next;
            stage_reg    <= stage_next;
            iter_reg     <= iter_next;
            m_tvalid_reg <= m_tvalid_next;
            hs_reg       <= hs_next;
            slp_reg      <= slp_next;
            sbp_reg      <= sbp_next;
            so_reg       <= so_next;
            pv_reg       <= pv_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        comp_reg <= comp_next;
        ta_reg   <= ta_next;
        tb_reg   <= tb_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next    = state_reg;
        wait_next     = wait_reg;
        stage_next    = stage_reg;
        iter_next     = iter_reg;
        neg_next      = neg_reg;
        x_next        = x_reg;
        comp_next     = comp_reg;
        ta_next       = ta_reg;
        tb_next       = tb_reg;
        acc_next      = acc_reg;
        q_next        = q_reg;
        so_next       = so_reg;
        pv_next       = pv_reg;
        hs_next       = hs_reg;
        slp_next      = slp_reg;
        sbp_next      = sbp_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        mul_start     = 1'b0;
        mul_a_w       = '0;
        mul_b_w       = '0;
        div_start     = 1'b0;
        div_n         = acc_reg;
        div_d         = tb_reg[BW:0];

        // Output register drains independently of the sequencer
        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next     = s_tdata[W-1:0];
                    iter_next  = '0;
                    stage_next = 2'd0;
                    wait_next  = 1'b0;
                    if (filter_mode_reg inside {MODE_LPF_2POLE, MODE_LPF_4POLE}) begin
                        state_next = ST_COMP;
                    end else if (filter_mode_reg == MODE_HP6) begin
                        state_next = ST_HP;
                    end else begin
                        state_next = ST_SVQ;
                    end
                end
            end

            // Input compensation r*x/2
            ST_COMP: begin
                mul_a_w = xe;
                mul_b_w = r_a;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    comp_next  = pr17;
                    state_next = ST_FB;
                end
            end

            // Resonance feedback and saturator argument
            ST_FB: begin
                mul_a_w = so3e - comp_reg;
                mul_b_w = k_a;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    stage_next = 2'd0;
                    if (t_arg > FOUR_A) begin
                        ta_next    = ONE_A;
                        state_next = ST_LZA;
                    end else if (t_arg < -FOUR_A) begin
                        ta_next    = -ONE_A;
                        state_next = ST_LZA;
                    end else begin
                        ta_next    = t_arg;
                        state_next = ST_TX2;
                    end
                end
            end

            ST_TX2: begin
                mul_a_w = ta_reg;
                mul_b_w = ta_reg;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    tb_next    = prf;
                    state_next = ST_TNUM;
                end
            end

            // Numerator x(27+x^2); dividend gets half the divisor for rounding
            ST_TNUM: begin
                mul_a_w = ta_reg;
                mul_b_w = C27_A + tb_reg;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    neg_next   = prod[AW-1];
                    acc_next   = mag + (den >>> 1);
                    tb_next    = den;
                    state_next = ST_TDIV;
                end
            end

            ST_TDIV: begin
                div_n = acc_reg;
                div_d = tb_reg[BW:0];
                if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (ddone_reg) begin
                    wait_next  = 1'b0;
                    ta_next    = neg_reg ? -quo : quo;
                    stage_next = 2'd0;
                    state_next = ST_LZA;
                end
            end

            // Ladder stage: zero tap on the new input
            ST_LZA: begin
                mul_a_w = xin;
                mul_b_w = AW'(ZERO_TAP_A);
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    acc_next   = prod;
                    state_next = ST_LZB;
                end
            end

            // Zero tap on the previous input, minus the stage output
            ST_LZB: begin
                mul_a_w = pv0e;
                mul_b_w = AW'(ZERO_TAP_B);
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    tb_next    = (((acc_reg + prod) + H16) >>> 16) - so0e;
                    state_next = ST_LG;
                end
            end

            // Stage update; the stage registers rotate so the current stage sits at 0
            ST_LG: begin
                mul_a_w = tb_reg;
                mul_b_w = g_a;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        so_next[i] = so_reg[i+1];
                        pv_next[i] = pv_reg[i+1];
                    end
                    so_next[3] = y_lg[W-1:0];
                    pv_next[3] = xin[W-1:0];
                    stage_next = stage_reg + 2'd1;
                    if (stage_reg != 2'd3) begin
                        state_next = ST_LZA;
                    end else if (!last_iter) begin
                        iter_next  = iter_reg + IW'(1);
                        state_next = ST_FB;
                    end else if (filter_mode_reg == MODE_LPF_2POLE) begin
                        ta_next    = sx(so_reg[2]);
                        state_next = ST_GAIN;
                    end else begin
                        state_next = ST_C2;
                    end
                end
            end

            // Soft clip c - c^3/6
            ST_C2: begin
                mul_a_w = c_cl;
                mul_b_w = c_cl;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    ta_next    = prf;
                    state_next = ST_C3;
                end
            end

            ST_C3: begin
                mul_a_w = ta_reg;
                mul_b_w = c_cl;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    tb_next    = prf;
                    state_next = ST_C6;
                end
            end

            ST_C6: begin
                mul_a_w = tb_reg;
                mul_b_w = AW'(SIXTH);
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    ta_next    = c_cl - pr16;
                    state_next = ST_GAIN;
                end
            end

            // Lowpass output gain
            ST_GAIN: begin
                mul_a_w = ta_reg;
                mul_b_w = gain24_a;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    res_next   = W'(sat_w(pr16));
                    state_next = ST_DONE;
                end
            end

            // One-pole highpass, one pass per oversample step
            ST_HP: begin
                mul_a_w = xe - hse;
                mul_b_w = a_a;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next = 1'b0;
                    hs_next   = W'(sat_w(hp_lp + hp_v));
                    if (last_iter) begin
                        res_next   = W'(sat_w(xe - hp_lp));
                        state_next = ST_DONE;
                    end else begin
                        iter_next = iter_reg + IW'(1);
                    end
                end
            end

            // Damping from resonance, Q_TOP - floor((39r+10)/20), no lower than Q_MIN
            ST_SVQ: begin
                div_n = r39_a;
                div_d = (BW+1)'(Q_DIVISOR);
                if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (ddone_reg) begin
                    wait_next  = 1'b0;
                    q_next     = (qq < AW'(Q_MIN)) ? 18'(Q_MIN) : qq[17:0];
                    state_next = ST_SQ;
                end
            end

            ST_SQ: begin
                mul_a_w = sbpe;
                mul_b_w = AW'(q_reg);
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    ta_next    = xe - slpe - pr16;
                    state_next = ST_SF1;
                end
            end

            ST_SF1: begin
                mul_a_w = ta_reg;
                mul_b_w = f_a;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    tb_next    = sbpe + pr16;
                    state_next = ST_SF2;
                end
            end

            // Lowpass integrator uses the unclamped bandpass value
            ST_SF2: begin
                mul_a_w = tb_reg;
                mul_b_w = f_a;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next = 1'b0;
                    sbp_next  = W'(clampm(tb_reg, TEN_A));
                    slp_next  = W'(clampm(lpn, TEN_A));
                    if (last_iter) begin
                        state_next = ST_SOUT;
                    end else begin
                        iter_next  = iter_reg + IW'(1);
                        state_next = ST_SQ;
                    end
                end
            end

            ST_SOUT: begin
                mul_a_w = sbpe;
                mul_b_w = bpgain_a;
                if (!wait_reg) begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end else if (mdone_reg) begin
                    wait_next  = 1'b0;
                    res_next   = W'(sat_w(pr16));
                    state_next = ST_DONE;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
                wait_next  = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Multiplier and divider are never active together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mbusy_reg && dbusy_reg))
        else $error("multiplier and divider busy together");

    // A new sample is only taken with the arithmetic units quiet
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!mbusy_reg && !dbusy_reg && !wait_reg))
        else $error("input ready while arithmetic in flight");

    // A result appears only out of the completion state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output valid raised outside completion");
`endif

endmodule

`default_nettype wire
